// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define JSU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define JSU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/jsu_pkg.sv =====
// Types and constants of the JSON string unescaper.
package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_STR  = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX0 = 3'd3,
        MODE_HEX1 = 3'd4,
        MODE_HEX2 = 3'd5,
        MODE_HEX3 = 3'd6
    } mode_t;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_CTRL = 2'd0;
    localparam logic [1:0] ERR_ESC  = 2'd1;
    localparam logic [1:0] ERR_HEX  = 2'd2;
    localparam logic [1:0] ERR_END  = 2'd3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_CTRL  = 8'h20;

    localparam int FIFO_DEPTH = 4;

    // All results caused by one input word.
    typedef struct packed {
        logic [1:0]      kind;
        logic [1:0]      n;        // 1 to 3
        logic [2:0][7:0] data;     // data[0] goes out first
        logic [1:0]      err;
        logic [15:0]     len;
    } bundle_t;

    // Hex digit decode: {valid, value}.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
        return r;
    endfunction

endpackage

// ===== sv/jsu_decode.sv =====
// Per-word decode: next state and the result bundle of one input word.
module jsu_decode #(
    parameter int LENGTH_WIDTH = 16
) (
    input  jsu_pkg::mode_t          mode,
    input  logic [11:0]             accum,
    input  logic [LENGTH_WIDTH-1:0] count,
    input  logic [7:0]              in_byte,
    output jsu_pkg::mode_t          mode_next,
    output logic [11:0]             accum_next,
    output logic [LENGTH_WIDTH-1:0] count_next,
    output logic                    push,
    output jsu_pkg::bundle_t        bundle
);

    logic [4:0]              hex;
    logic [15:0]             cp;
    logic [1:0]              add_n;
    logic [LENGTH_WIDTH:0]   sum;
    logic [LENGTH_WIDTH-1:0] count_sat;

    assign hex = jsu_pkg::hex_value(in_byte);
    assign cp  = {accum, hex[3:0]};
    assign sum = {1'b0, count} + (LENGTH_WIDTH + 1)'(add_n);
    assign count_sat = sum[LENGTH_WIDTH] ? '1 : sum[LENGTH_WIDTH-1:0];

    always_comb
    begin
        mode_next  = mode;
        accum_next = accum;
        count_next = count;
        push       = 1'b0;
        bundle     = '0;
        add_n      = 2'd0;
        case (mode)
            jsu_pkg::MODE_STR, jsu_pkg::MODE_ESC, jsu_pkg::MODE_HEX0,
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3:
            begin
                if (in_byte < jsu_pkg::CH_CTRL) begin
                    push        = 1'b1;
                    bundle.kind = jsu_pkg::KIND_ERROR;
                    bundle.n    = 2'd1;
                    bundle.err  = (in_byte == 8'h00) ? jsu_pkg::ERR_END : jsu_pkg::ERR_CTRL;
                    mode_next   = jsu_pkg::MODE_IDLE;
                    accum_next  = 12'd0;
                end else if (mode == jsu_pkg::MODE_STR) begin
                    if (in_byte == jsu_pkg::CH_QUOTE) begin
                        push        = 1'b1;
                        bundle.kind = jsu_pkg::KIND_CLOSE;
                        bundle.n    = 2'd1;
                        bundle.len  = 16'(count);
                        mode_next   = jsu_pkg::MODE_IDLE;
                    end else if (in_byte == jsu_pkg::CH_BSL) begin
                        mode_next = jsu_pkg::MODE_ESC;
                    end else begin
                        push           = 1'b1;
                        bundle.n       = 2'd1;
                        bundle.data[0] = in_byte;
                        add_n          = 2'd1;
                    end
                end else if (mode == jsu_pkg::MODE_ESC) begin
                    push      = 1'b1;
                    bundle.n  = 2'd1;
                    add_n     = 2'd1;
                    mode_next = jsu_pkg::MODE_STR;
                    case (in_byte)
                        8'h6E: bundle.data[0] = 8'h0A;
                        8'h5C: bundle.data[0] = 8'h5C;
                        8'h2F: bundle.data[0] = 8'h2F;
                        8'h62: bundle.data[0] = 8'h08;
                        8'h66: bundle.data[0] = 8'h0C;
                        8'h72: bundle.data[0] = 8'h0D;
                        8'h74: bundle.data[0] = 8'h09;
                        8'h22: bundle.data[0] = 8'h22;
                        8'h75:
                        begin
                            push       = 1'b0;
                            bundle.n   = 2'd0;
                            add_n      = 2'd0;
                            mode_next  = jsu_pkg::MODE_HEX0;
                            accum_next = 12'd0;
                        end
                        default:
                        begin
                            add_n       = 2'd0;
                            bundle.kind = jsu_pkg::KIND_ERROR;
                            bundle.err  = jsu_pkg::ERR_ESC;
                            mode_next   = jsu_pkg::MODE_IDLE;
                            accum_next  = 12'd0;
                        end
                    endcase
                end else if (!hex[4]) begin
                    push        = 1'b1;
                    bundle.kind = jsu_pkg::KIND_ERROR;
                    bundle.n    = 2'd1;
                    bundle.err  = jsu_pkg::ERR_HEX;
                    mode_next   = jsu_pkg::MODE_IDLE;
                    accum_next  = 12'd0;
                end else if (mode != jsu_pkg::MODE_HEX3) begin
                    accum_next = {accum[7:0], hex[3:0]};
                    case (mode)
                        jsu_pkg::MODE_HEX0: mode_next = jsu_pkg::MODE_HEX1;
                        jsu_pkg::MODE_HEX1: mode_next = jsu_pkg::MODE_HEX2;
                        default:            mode_next = jsu_pkg::MODE_HEX3;
                    endcase
                end else begin
                    // Last hex digit: emit the code point as UTF-8.
                    push       = 1'b1;
                    mode_next  = jsu_pkg::MODE_STR;
                    accum_next = 12'd0;
                    if (cp < 16'h0080) begin
                        bundle.n       = 2'd1;
                        bundle.data[0] = cp[7:0];
                    end else if (cp < 16'h0800) begin
                        bundle.n       = 2'd2;
                        bundle.data[0] = {3'b110, cp[10:6]};
                        bundle.data[1] = {2'b10, cp[5:0]};
                    end else begin
                        bundle.n       = 2'd3;
                        bundle.data[0] = {4'b1110, cp[15:12]};
                        bundle.data[1] = {2'b10, cp[11:6]};
                        bundle.data[2] = {2'b10, cp[5:0]};
                    end
                    add_n = bundle.n;
                end
            end
            default:
            begin
                // Idle, and the unused code: wait for an opening quote.
                mode_next = jsu_pkg::MODE_IDLE;
                if (in_byte == jsu_pkg::CH_QUOTE) begin
                    mode_next  = jsu_pkg::MODE_STR;
                    accum_next = 12'd0;
                    count_next = '0;
                end
            end
        endcase
        if (add_n != 2'd0) count_next = count_sat;
    end

endmodule

// ===== sv/jsu_emit.sv =====
// Result queue: holds bundles and sends their results one word at a time.
module jsu_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  jsu_pkg::bundle_t bundle,
    output logic             full,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       data_byte,
    output logic [1:0]       error_code,
    output logic [15:0]      string_length,
    output logic             last
);

    localparam int PW = $clog2(jsu_pkg::FIFO_DEPTH);

    jsu_pkg::bundle_t fifo_reg [jsu_pkg::FIFO_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]      fill_reg;
    logic [1:0]       idx_reg;
    jsu_pkg::bundle_t head;
    logic             pop;

    assign head      = fifo_reg[rd_ptr_reg];
    assign full      = (fill_reg == (PW + 1)'(jsu_pkg::FIFO_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign last      = (idx_reg == head.n - 2'd1);
    assign pop       = out_valid && out_ready && last;

    assign kind          = head.kind;
    assign data_byte     = (head.kind == jsu_pkg::KIND_DATA) ? head.data[idx_reg] : 8'h00;
    assign error_code    = (head.kind == jsu_pkg::KIND_ERROR) ? head.err : 2'd0;
    assign string_length = (head.kind == jsu_pkg::KIND_CLOSE) ? head.len : 16'd0;

    always_ff @(posedge clk)
    begin
        if (push) fifo_reg[wr_ptr_reg] <= bundle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            idx_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop) rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (push && !pop) fill_reg <= fill_reg + (PW + 1)'(1);
            else if (!push && pop) fill_reg <= fill_reg - (PW + 1)'(1);
            if (pop) idx_reg <= 2'd0;
            else if (out_valid && out_ready) idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

// ===== sv/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescaper with UTF-8 output of u escapes.
//
// Takes one byte of JSON text per cycle while in_ready is high. While idle
// it waits for a double quote; everything else is dropped. Inside a string,
// plain bytes come out as data words, simple escapes come out as their
// character, and a u escape with four hex digits comes out as 1 to 3 UTF-8
// bytes (no surrogate pairing). The closing quote gives a close word with
// the decoded length, which saturates at 2^LENGTH_WIDTH-1 and shows its low
// 16 bits. A control byte, an unknown escape, a bad hex digit or a zero byte
// inside a string gives one error word and returns to idle. Rate: one input
// byte per cycle while in_ready is high; decode is a single combinational
// pass on the state registers, and all results of one byte go into a 4-deep
// bundle queue that drains one result word per cycle while out_ready is
// high. in_ready drops only when that queue is full, i.e. after the output
// side has stalled. Each result is registered in the queue before output.
module json_string_unescape_utf8 #(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [1:0]  error_code,
    output logic [15:0] string_length,
    output logic        last
);

    jsu_pkg::mode_t          mode_reg, mode_next;
    logic [11:0]             accum_reg, accum_next;
    logic [LENGTH_WIDTH-1:0] count_reg, count_next;
    logic                    dec_push;
    jsu_pkg::bundle_t        dec_bundle;
    logic                    full;
    logic                    accept;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    // Decode of the current byte against the scan state.
    jsu_decode #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_decode (
        .mode      (mode_reg),
        .accum     (accum_reg),
        .count     (count_reg),
        .in_byte   (in_byte),
        .mode_next (mode_next),
        .accum_next(accum_next),
        .count_next(count_next),
        .push      (dec_push),
        .bundle    (dec_bundle)
    );

    // Scan state moves only on an accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= jsu_pkg::MODE_IDLE;
            accum_reg <= 12'd0;
            count_reg <= '0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            accum_reg <= accum_next;
            count_reg <= count_next;
        end
    end

    // Result queue and output serializer.
    jsu_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (accept && dec_push),
        .bundle       (dec_bundle),
        .full         (full),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .error_code   (error_code),
        .string_length(string_length),
        .last         (last)
    );

endmodule

// ===== sv/jsu_checker.sv =====
// Port-level checks of the JSON string unescaper, bound to the top level.
`include "assert_macros.svh"

module jsu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  in_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [7:0]  data_byte,
    input logic [1:0]  error_code,
    input logic [15:0] string_length,
    input logic        last
);

    logic        stalled;
    logic        non_data;
    logic        fields_ok;
    logic [28:0] out_word;

    assign stalled   = out_valid && !out_ready;
    assign non_data  = out_valid && kind != jsu_pkg::KIND_DATA;
    assign out_word  = {kind, data_byte, error_code, string_length, last};
    assign fields_ok = kind <= jsu_pkg::KIND_ERROR
                       && (kind == jsu_pkg::KIND_ERROR || error_code == 2'd0)
                       && (kind == jsu_pkg::KIND_CLOSE || string_length == 16'd0);

    `JSU_ASSERT_NXT(a_out_hold, stalled, out_valid && $stable(out_word), "stalled word changed")
    `JSU_ASSERT_IMP(a_single, non_data, last, "close or error word not last")
    `JSU_ASSERT_IMP(a_zero_fields, non_data, data_byte == 8'h00, "data byte on non-data word")
    `JSU_ASSERT_IMP(a_kind_code, out_valid, fields_ok, "field not zero for its kind")

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);
